@@ hw/rtl/extended_binary_l2r_gcd_defines.svh @@
// Assertion macros used by the checker file.
`ifndef EXTENDED_BINARY_L2R_GCD_DEFINES_SVH
`define EXTENDED_BINARY_L2R_GCD_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define EBLGCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("eblgcd assertion failed");

// Concurrent assertion that also holds across reset.
`define EBLGCD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("eblgcd assertion failed");

`endif

@@ hw/rtl/eblgcd_pkg.sv @@
package eblgcd_pkg;

    localparam int EBLGCD_DEF_WIDTH = 64;

    // Status of the item queue between the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ hw/rtl/eblgcd_front.sv @@
module eblgcd_front #(
    parameter int WIDTH = 64
) (
    input  logic                    start,
    input  logic [WIDTH-1:0]        i_op_a,
    input  logic [WIDTH-1:0]        i_op_b,
    input  eblgcd_pkg::t_q_status   i_q_status,
    output logic                    o_push,
    output logic [2*WIDTH:0]        o_item,
    output logic                    o_busy
);
    import eblgcd_pkg::*;

    localparam logic [WIDTH-2:0] MAG_MAX = '1;

    logic [WIDTH-1:0] a_abs;
    logic [WIDTH-1:0] b_abs;
    logic [WIDTH-2:0] a_mag;
    logic [WIDTH-2:0] b_mag;
    logic             a_neg;
    logic             b_neg;
    logic             swap;

    always_comb begin
        a_neg = i_op_a[WIDTH-1];
        b_neg = i_op_b[WIDTH-1];
        a_abs = a_neg ? (~i_op_a + WIDTH'(1)) : i_op_a;
        b_abs = b_neg ? (~i_op_b + WIDTH'(1)) : i_op_b;
        // The most negative value saturates to the largest magnitude.
        a_mag = a_abs[WIDTH-1] ? MAG_MAX : a_abs[WIDTH-2:0];
        b_mag = b_abs[WIDTH-1] ? MAG_MAX : b_abs[WIDTH-2:0];
        swap  = a_mag < b_mag;
    end

    assign o_busy = i_q_status.full;
    assign o_push = start && !i_q_status.full;
    assign o_item = {swap, b_neg, a_neg, b_mag, a_mag};

endmodule

@@ hw/rtl/eblgcd_queue.sv @@
module eblgcd_queue #(
    parameter int DW = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [DW-1:0]           i_data,
    input  logic                    i_pop,
    output logic [DW-1:0]           o_data,
    output eblgcd_pkg::t_q_status   o_status
);
    import eblgcd_pkg::*;

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rp];
    assign o_status.full  = r_cnt[1];
    assign o_status.empty = (r_cnt == 2'd0);

endmodule

@@ hw/rtl/eblgcd_back.sv @@
module eblgcd_back #(
    parameter int WIDTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  eblgcd_pkg::t_q_status   i_q_status,
    input  logic [2*WIDTH:0]        i_item,
    output logic                    o_pop,
    output logic                    o_done,
    output logic [WIDTH-2:0]        o_gcd_value,
    output logic [WIDTH-1:0]        o_coef_a,
    output logic [WIDTH-1:0]        o_coef_b
);
    import eblgcd_pkg::*;

    localparam int KW = $clog2(WIDTH);
    localparam logic [KW-1:0] CNT_LAST = KW'(WIDTH - 1);
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEAD  = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    localparam logic [1:0] OP_QB = 2'd0;
    localparam logic [1:0] OP_QA = 2'd1;
    localparam logic [1:0] OP_RS = 2'd2;
    localparam logic [1:0] OP_RT = 2'd3;

    logic [2:0]       r_state;
    logic [WIDTH-2:0] r_amag, r_bmag, r_u3, r_v3, r_qa, r_qb, r_dvs;
    logic             r_aneg, r_bneg;
    logic [WIDTH-1:0] r_u1, r_u2, r_v1, r_v2;
    logic [KW-1:0]    r_k, r_cnt;
    logic [1:0]       r_op;
    logic [WIDTH-1:0] r_rem, r_quo, r_s;
    logic             r_done;
    logic [WIDTH-2:0] r_g;
    logic [WIDTH-1:0] r_cs, r_ct;

    logic [WIDTH-2:0] it_amag, it_bmag;
    logic             it_aneg, it_bneg, it_swap;

    logic [KW-1:0]    lead_u, lead_v;
    logic [WIDTH-2:0] sh, nu3;
    logic [WIDTH-1:0] nu1, nu2, v1k, v2k;
    logic [WIDTH:0]   rem_sh;
    logic             ge;
    logic [WIDTH-1:0] n_rem, n_quo;
    logic [WIDTH-1:0] u1_abs, u2_abs, rem_signed;
    logic             rem_neg;

    assign {it_swap, it_bneg, it_aneg, it_bmag, it_amag} = i_item;
    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;

    // Leading-one positions of the two remainders.
    always_comb begin
        lead_u = '0;
        lead_v = '0;
        for (int i = 1; i < WIDTH - 1; i++) begin
            if (r_u3[i]) begin
                lead_u = KW'(i);
            end
            if (r_v3[i]) begin
                lead_v = KW'(i);
            end
        end
    end

    always_comb begin
        sh  = r_v3 << r_k;
        v1k = r_v1 << r_k;
        v2k = r_v2 << r_k;
        if (sh > r_u3) begin
            nu3 = sh - r_u3;
            nu1 = v1k - r_u1;
            nu2 = v2k - r_u2;
        end else begin
            nu3 = r_u3 - sh;
            nu1 = r_u1 - v1k;
            nu2 = r_u2 - v2k;
        end
    end

    // One bit of restoring division per cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[WIDTH-1]};
        ge     = rem_sh >= {2'b00, r_dvs};
        n_rem  = ge ? WIDTH'(rem_sh - {2'b00, r_dvs}) : rem_sh[WIDTH-1:0];
        n_quo  = {r_quo[WIDTH-2:0], ge};
    end

    always_comb begin
        u1_abs     = r_u1[WIDTH-1] ? (~r_u1 + ONE) : r_u1;
        u2_abs     = r_u2[WIDTH-1] ? (~r_u2 + ONE) : r_u2;
        rem_neg    = (r_op == OP_RS) ? (r_u1[WIDTH-1] ^ r_aneg) : (r_u2[WIDTH-1] ^ r_bneg);
        rem_signed = rem_neg ? (~n_rem + ONE) : n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_state <= S_LEAD;
                    end
                end
                S_LEAD: begin
                    r_state <= (r_v3 == '0) ? S_FINAL : S_STEP;
                end
                S_STEP: begin
                    r_state <= S_LEAD;
                end
                S_FINAL: begin
                    if ((r_u3 == r_amag) || (r_u3 == r_bmag)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if ((r_cnt == CNT_LAST) && (r_op == OP_RT)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_amag <= it_amag;
                r_bmag <= it_bmag;
                r_aneg <= it_aneg;
                r_bneg <= it_bneg;
                if (it_swap) begin
                    r_u1 <= '0;
                    r_u2 <= ONE;
                    r_u3 <= it_bmag;
                    r_v1 <= ONE;
                    r_v2 <= '0;
                    r_v3 <= it_amag;
                end else begin
                    r_u1 <= ONE;
                    r_u2 <= '0;
                    r_u3 <= it_amag;
                    r_v1 <= '0;
                    r_v2 <= ONE;
                    r_v3 <= it_bmag;
                end
            end
            S_LEAD: begin
                r_k <= lead_u - lead_v;
            end
            S_STEP: begin
                if (nu3 < r_v3) begin
                    r_u1 <= r_v1;
                    r_u2 <= r_v2;
                    r_u3 <= r_v3;
                    r_v1 <= nu1;
                    r_v2 <= nu2;
                    r_v3 <= nu3;
                end else begin
                    r_u1 <= nu1;
                    r_u2 <= nu2;
                    r_u3 <= nu3;
                end
            end
            S_FINAL: begin
                r_g <= r_u3;
                if (r_u3 == r_amag) begin
                    r_cs <= r_aneg ? '1 : ONE;
                    r_ct <= '0;
                end else if (r_u3 == r_bmag) begin
                    r_cs <= '0;
                    r_ct <= r_bneg ? '1 : ONE;
                end
                r_op  <= OP_QB;
                r_cnt <= '0;
                r_rem <= '0;
                r_quo <= {1'b0, r_bmag};
                r_dvs <= r_u3;
            end
            S_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_op  <= r_op + 2'd1;
                    case (r_op)
                        OP_QB: begin
                            r_qb  <= n_quo[WIDTH-2:0];
                            r_quo <= {1'b0, r_amag};
                        end
                        OP_QA: begin
                            r_qa  <= n_quo[WIDTH-2:0];
                            r_quo <= u1_abs;
                            r_dvs <= r_qb;
                        end
                        OP_RS: begin
                            r_s   <= rem_signed;
                            r_quo <= u2_abs;
                            r_dvs <= r_qa;
                        end
                        default: begin
                            r_cs  <= r_s;
                            r_ct  <= rem_signed;
                            r_quo <= n_quo;
                        end
                    endcase
                end else begin
                    r_cnt <= r_cnt + KW'(1);
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_done      = r_done;
    assign o_gcd_value = r_g;
    assign o_coef_a    = r_cs;
    assign o_coef_b    = r_ct;

endmodule

@@ hw/rtl/extended_binary_l2r_gcd.sv @@
// Each reduction round passes through a leading-bit compare state, then a shift
// and subtract state; the cofactor reduction runs four bit-serial divisions.
// The back part works on one item at a time; a two-item queue absorbs starts.
// o_done is high for one cycle when results are ready; the receiver cannot stall.
// Synchronous active-low reset empties the queue and idles the back part.
module extended_binary_l2r_gcd #(
    parameter int WIDTH = eblgcd_pkg::EBLGCD_DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_op_a,
    input  logic [WIDTH-1:0] i_op_b,
    output logic             o_done,
    output logic [WIDTH-2:0] o_gcd_value,
    output logic [WIDTH-1:0] o_coef_a,
    output logic [WIDTH-1:0] o_coef_b
);
    import eblgcd_pkg::*;

    localparam int DW = 2 * WIDTH + 1;

    t_q_status      q_status;
    logic           push;
    logic           pop;
    logic [DW-1:0]  item_in;
    logic [DW-1:0]  item_out;

    eblgcd_front #(.WIDTH(WIDTH)) u_front (
        .start      (start),
        .i_op_a     (i_op_a),
        .i_op_b     (i_op_b),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (item_in),
        .o_busy     (busy)
    );

    eblgcd_queue #(.DW(DW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (item_in),
        .i_pop    (pop),
        .o_data   (item_out),
        .o_status (q_status)
    );

    eblgcd_back #(.WIDTH(WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_item      (item_out),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_gcd_value (o_gcd_value),
        .o_coef_a    (o_coef_a),
        .o_coef_b    (o_coef_b)
    );

endmodule

@@ hw/rtl/eblgcd_checker.sv @@
`include "extended_binary_l2r_gcd_defines.svh"

module eblgcd_checker #(
    parameter int WIDTH = eblgcd_pkg::EBLGCD_DEF_WIDTH
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [WIDTH-1:0] i_op_a,
    input logic [WIDTH-1:0] i_op_b,
    input logic             o_done,
    input logic [WIDTH-2:0] o_gcd_value,
    input logic [WIDTH-1:0] o_coef_a,
    input logic [WIDTH-1:0] o_coef_b
);
    import eblgcd_pkg::*;

    // A reset cycle leaves the queue empty and no result pending.
    `EBLGCD_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !busy && !o_done)

    // Two results never arrive in consecutive cycles.
    `EBLGCD_ASSERT(a_done_gap, i_clk, i_rst_n, o_done |=> !o_done)

    // A zero gcd only comes from two zero operands; the cofactors are then one and zero.
    `EBLGCD_ASSERT(a_zero_gcd, i_clk, i_rst_n,
        o_done && (o_gcd_value == '0) |-> (o_coef_a == WIDTH'(1)) && (o_coef_b == '0))

endmodule

bind extended_binary_l2r_gcd eblgcd_checker #(.WIDTH(WIDTH)) u_eblgcd_checker (.*);

@@ test/extended_binary_l2r_gcd_test.sv @@
`timescale 1ns / 1ps

class gcd_scoreboard;
    logic [62:0] exp_gcd[$];
    logic [63:0] exp_sa[$];
    logic [63:0] exp_tb[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function logic [63:0] neg64(logic [63:0] x);
        return ~x + 64'd1;
    endfunction

    static function logic [63:0] mag64(logic [63:0] x);
        logic [63:0] m;
        m = x[63] ? neg64(x) : x;
        if (m > 64'h7fff_ffff_ffff_ffff) m = 64'h7fff_ffff_ffff_ffff;
        return m;
    endfunction

    static function int msb_pos(logic [63:0] x);
        for (int i = 63; i > 0; i--) if (x[i]) return i;
        return 0;
    endfunction

    static function logic [63:0] rem_toward_zero(logic [63:0] c, logic [63:0] q);
        logic [63:0] cm, r;
        cm = c[63] ? neg64(c) : c;
        r = (q != 0) ? cm % q : cm;
        return c[63] ? neg64(r) : r;
    endfunction

    // Works out gcd and reduced cofactors of one accepted item.
    function void note_operands(logic [63:0] a, logic [63:0] b);
        logic [63:0] am, bm, u1, u2, u3, v1, v2, v3, t, sh, s, tc;
        int k;
        am = mag64(a);
        bm = mag64(b);
        u1 = 1; u2 = 0; u3 = am;
        v1 = 0; v2 = 1; v3 = bm;
        if (u3 < v3) begin
            t = u1; u1 = v1; v1 = t;
            t = u2; u2 = v2; v2 = t;
            t = u3; u3 = v3; v3 = t;
        end
        while (v3 != 0) begin
            k = msb_pos(u3) - msb_pos(v3);
            sh = v3 << k;
            if (sh > u3) begin
                u3 = sh - u3;
                u1 = (v1 << k) - u1;
                u2 = (v2 << k) - u2;
            end else begin
                u3 = u3 - sh;
                u1 = u1 - (v1 << k);
                u2 = u2 - (v2 << k);
            end
            if (u3 < v3) begin
                t = u1; u1 = v1; v1 = t;
                t = u2; u2 = v2; v2 = t;
                t = u3; u3 = v3; v3 = t;
            end
        end
        if (u3 == am) begin
            s = a[63] ? '1 : 64'd1;
            tc = 0;
        end else if (u3 == bm) begin
            s = 0;
            tc = b[63] ? '1 : 64'd1;
        end else begin
            s = rem_toward_zero(u1, bm / u3);
            tc = rem_toward_zero(u2, am / u3);
            if (a[63]) s = neg64(s);
            if (b[63]) tc = neg64(tc);
        end
        exp_gcd.push_back(u3[62:0]);
        exp_sa.push_back(s);
        exp_tb.push_back(tc);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [62:0] g, logic [63:0] sa, logic [63:0] tb);
        logic [62:0] eg;
        logic [63:0] es, et;
        if (exp_gcd.size() == 0) begin
            report("unexpected result", {1'b0, g}, 64'd0);
            return;
        end
        eg = exp_gcd.pop_front();
        es = exp_sa.pop_front();
        et = exp_tb.pop_front();
        if (g !== eg) report("gcd_value", {1'b0, g}, {1'b0, eg});
        if (sa !== es) report("coef_a", sa, es);
        if (tb !== et) report("coef_b", tb, et);
    endtask
endclass

module extended_binary_l2r_gcd_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_op_a;
    logic [63:0] i_op_b;
    logic        o_done;
    logic [62:0] o_gcd_value;
    logic [63:0] o_coef_a;
    logic [63:0] o_coef_b;

    gcd_scoreboard gcd_book;
    int            idle_pct;
    longint        cycle_count;

    extended_binary_l2r_gcd u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op_a      (i_op_a),
        .i_op_b      (i_op_b),
        .o_done      (o_done),
        .o_gcd_value (o_gcd_value),
        .o_coef_a    (o_coef_a),
        .o_coef_b    (o_coef_b)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial gcd_book = new();

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) gcd_book.check_result(o_gcd_value, o_coef_a, o_coef_b);
        if (i_rst_n && start && !busy) gcd_book.note_operands(i_op_a, i_op_b);
        if (cycle_count > 4000000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Start stays high between back-to-back items; it drops only while idling.
    task send_item(logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_op_a <= a;
        i_op_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operands that may share a random factor, so that the gcd is sometimes non-trivial.
    function automatic logic [63:0] shaped(logic [63:0] f);
        logic [63:0] x;
        case ($urandom_range(5))
            0: x = rand64();
            1: x = f * 64'($urandom_range(1000));
            2: x = f * {32'd0, $urandom()};
            3: x = rand64() >> $urandom_range(63);
            4: x = {32'd0, $urandom()} << $urandom_range(31);
            default: x = 64'($urandom_range(20));
        endcase
        if ($urandom_range(1)) x = ~x + 64'd1;
        return x;
    endfunction

    localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;

    initial begin
        logic [63:0] f;
        cycle_count = 0;
        idle_pct = 0;
        i_rst_n = 0;
        start = 0;
        i_op_a = 0;
        i_op_b = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_item(0, 0);
        send_item(5, 0);
        send_item(0, -64'sd7);
        send_item(-64'sd12, 0);
        send_item(12, 18);
        send_item(-64'sd12, 18);
        send_item(12, -64'sd18);
        send_item(-64'sd240, -64'sd46);
        send_item(6, 3);
        send_item(3, -64'sd6);
        send_item(MAXP, MAXP);
        send_item(MAXP, MAXP - 1);
        send_item(MINN, 3);
        send_item(MINN, MINN);
        send_item(MINN, MAXP);
        send_item(1, MAXP);
        send_item(MAXP - 1, 64'h4000_0000_0000_0000);
        send_item(64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555);
        send_item(64'haaaa_aaaa_aaaa_aaab, 64'h5555_5555_5555_5555);
        send_item(7, 7);

        for (int n = 0; n < 1330; n++) begin
            case (n / 266)
                0: idle_pct = 0;
                1: idle_pct = 83;
                2: idle_pct = 15;
                3: idle_pct = 83;
                default: idle_pct = $urandom_range(1) ? 0 : 50;
            endcase
            if (n == 600) begin
                // Let the block drain completely before carrying on.
                start <= 1'b0;
                @(negedge i_clk);
                while (gcd_book.exp_gcd.size() != 0) @(negedge i_clk);
            end
            f = rand64() >> $urandom_range(63);
            if (f == 0) f = 1;
            send_item(shaped(f), shaped(f));
        end

        start <= 1'b0;
        while (gcd_book.exp_gcd.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        if (gcd_book.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
